[design/window_liveness_silence_tracker_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the window liveness tracker checker
// ---------------------------------------------------------------------------
`ifndef WINDOW_LIVENESS_SILENCE_TRACKER_MACROS_SVH
`define WINDOW_LIVENESS_SILENCE_TRACKER_MACROS_SVH

// Checked outside reset.
`define WLST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");

// Checked in every cycle, reset included.
`define WLST_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

[design/wlst_pkg.sv]
// ---------------------------------------------------------------------------
// wlst_pkg
// Shared types and constants of the window liveness tracker.
// ---------------------------------------------------------------------------
package wlst_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [31:0] THRESH_RESET = 32'd60000;
   localparam int          CSR_ADDR_W   = 3;
   // register index sits above the byte lanes
   localparam logic        CSR_IDX_THRESH = 1'b0;

   typedef enum logic [1:0] {
      KIND_SILENCE = 2'd0,
      KIND_EXITED  = 2'd1,
      KIND_DROPPED = 2'd2
   } kind_type;

   localparam logic MODE_OBSERVE = 1'b0;
   localparam logic MODE_SWEEP   = 1'b1;

   typedef struct packed {
      logic load;        // capture transaction, rewind index
      logic scan_step;   // lookup one entry
      logic resolve;     // update table, maybe emit one event
      logic sweep_step;  // end-of-round work on one entry
   } ctl_cmd_type;

   typedef struct packed {
      logic mode;        // captured mode
      logic idx_end;     // index at last entry
      logic out_free;    // result register can take a new event
   } ctl_status_type;

endpackage

[design/wlst_if.sv]
// ---------------------------------------------------------------------------
// wlst_req_if / wlst_rsp_if
// Valid/ready channels of the window liveness tracker.
// ---------------------------------------------------------------------------
interface wlst_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [7:0]  workspace_id;
   logic [15:0] window_id;
   logic [21:0] proc_id;
   logic [47:0] now_ms;
   logic [31:0] wall_stamp;

   modport source (output valid, mode, workspace_id, window_id, proc_id, now_ms,
                   wall_stamp, input ready);
   modport sink   (input valid, mode, workspace_id, window_id, proc_id, now_ms,
                   wall_stamp, output ready);
endinterface

interface wlst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [7:0]  event_workspace;
   logic [15:0] event_window;
   logic [31:0] event_stamp;
   logic        last;

   modport source (output valid, event_kind, event_workspace, event_window, event_stamp,
                   last, input ready);
   modport sink   (input valid, event_kind, event_workspace, event_window, event_stamp,
                   last, output ready);
endinterface

[design/wlst_ctrl.sv]
// ---------------------------------------------------------------------------
// wlst_ctrl
// Sequencer: idle, table scan, resolve, end-of-round sweep.
// ---------------------------------------------------------------------------
module wlst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  wlst_pkg::ctl_status_type status,
   output wlst_pkg::ctl_cmd_type    cmd
);
   import wlst_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE,
      ST_SWEEP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.idx_end) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (status.out_free) begin
               cmd.resolve = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (status.out_free) begin
               cmd.sweep_step = 1'b1;
               if (status.idx_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // mode is captured by load; pick the path in the cycle after, from the scan state
      if (state_ff == ST_SCAN && status.mode == MODE_SWEEP) begin
         cmd.scan_step = 1'b0;
         state_in      = ST_SWEEP;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/wlst_dpath.sv]
// ---------------------------------------------------------------------------
// wlst_dpath
// Track table, lookup registers, resolve logic and result register.
// ---------------------------------------------------------------------------
module wlst_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  wlst_pkg::ctl_cmd_type    cmd,
   output wlst_pkg::ctl_status_type status,
   input  logic                     in_mode,
   input  logic [7:0]               in_workspace_id,
   input  logic [15:0]              in_window_id,
   input  logic [21:0]              in_proc_id,
   input  logic [47:0]              in_now_ms,
   input  logic [31:0]              in_wall_stamp,
   input  logic [31:0]              threshold,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_event_kind,
   output logic [7:0]               rsp_event_workspace,
   output logic [15:0]              rsp_event_window,
   output logic [31:0]              rsp_event_stamp,
   output logic                     rsp_last
);
   import wlst_pkg::*;

   // captured transaction
   logic        mode_ff;
   logic [23:0] key_ff;
   logic [21:0] pid_ff;
   logic [47:0] now_ff;
   logic [31:0] stamp_ff;

   // table
   logic [23:0] key_mem   [TABLE_DEPTH];
   logic [21:0] pid_mem   [TABLE_DEPTH];
   logic [47:0] start_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff, sent_ff, seen_ff;
   logic [TABLE_DEPTH-1:0] valid_in, sent_in, seen_in;

   // lookup
   logic [IDX_W-1:0] idx_ff, hit_idx_ff, free_idx_ff;
   logic             hit_ff, free_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff;
   logic [23:0] out_key_ff;
   logic [31:0] out_stamp_ff;
   logic        out_last_ff;

   logic        emit;
   kind_type    emit_kind;
   logic [23:0] emit_key;
   logic        emit_last;

   logic             out_free;
   logic [IDX_W-1:0] tgt_idx;
   logic [21:0]      hit_pid;
   logic [47:0]      elapsed;
   logic             tbl_wr;
   logic [TABLE_DEPTH-1:0] pend, pend_hi;
   logic             key_match;

   assign out_free = !out_valid_ff || rsp_ready;
   assign status.mode     = mode_ff;
   assign status.idx_end  = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign status.out_free = out_free;

   assign key_match = valid_ff[idx_ff] && (key_mem[idx_ff] == key_ff);
   assign tgt_idx   = hit_ff ? hit_idx_ff : free_idx_ff;
   assign hit_pid   = pid_mem[hit_idx_ff];
   assign elapsed   = now_ff - start_mem[hit_idx_ff];
   assign pend      = valid_ff & ~seen_ff;
   assign pend_hi   = (pend >> idx_ff) >> 1;

   always_comb begin
      valid_in  = valid_ff;
      sent_in   = sent_ff;
      seen_in   = seen_ff;
      emit      = 1'b0;
      emit_kind = KIND_SILENCE;
      emit_key  = key_ff;
      emit_last = 1'b1;
      tbl_wr    = 1'b0;
      if (cmd.resolve) begin
         if (hit_ff) begin
            seen_in[hit_idx_ff] = 1'b1;
            if (hit_pid != pid_ff) begin
               tbl_wr              = 1'b1;
               sent_in[hit_idx_ff] = 1'b0;
            end else if (!sent_ff[hit_idx_ff] && elapsed >= {16'd0, threshold}) begin
               emit                = 1'b1;
               sent_in[hit_idx_ff] = 1'b1;
            end
         end else if (free_ff) begin
            tbl_wr                = 1'b1;
            valid_in[free_idx_ff] = 1'b1;
            sent_in[free_idx_ff]  = 1'b0;
            seen_in[free_idx_ff]  = 1'b1;
         end else begin
            emit      = 1'b1;
            emit_kind = KIND_DROPPED;
         end
      end
      if (cmd.sweep_step) begin
         if (pend[idx_ff]) begin
            emit             = 1'b1;
            emit_kind        = KIND_EXITED;
            emit_key         = key_mem[idx_ff];
            emit_last        = (pend_hi == '0);
            valid_in[idx_ff] = 1'b0;
            sent_in[idx_ff]  = 1'b0;
         end
         seen_in[idx_ff] = 1'b0;
      end
      out_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         sent_ff      <= '0;
         seen_ff      <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         sent_ff      <= sent_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
         if (cmd.load) begin
            idx_ff  <= '0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (cmd.scan_step || cmd.sweep_step) begin
            idx_ff <= idx_ff + IDX_W'(1);
            if (cmd.scan_step) begin
               if (key_match && !hit_ff) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= idx_ff;
               end
               if (!valid_ff[idx_ff] && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= idx_ff;
               end
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= in_mode;
         key_ff   <= {in_workspace_id, in_window_id};
         pid_ff   <= in_proc_id;
         now_ff   <= in_now_ms;
         stamp_ff <= in_wall_stamp;
      end
      if (tbl_wr) begin
         pid_mem[tgt_idx]   <= pid_ff;
         start_mem[tgt_idx] <= now_ff;
         if (!hit_ff) begin
            key_mem[tgt_idx] <= key_ff;
         end
      end
      if (emit) begin
         out_kind_ff  <= emit_kind;
         out_key_ff   <= emit_key;
         out_stamp_ff <= stamp_ff;
         out_last_ff  <= emit_last;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_event_kind      = out_kind_ff;
   assign rsp_event_workspace = out_key_ff[23:16];
   assign rsp_event_window    = out_key_ff[15:0];
   assign rsp_event_stamp     = out_stamp_ff;
   assign rsp_last            = out_last_ff;

endmodule

[design/window_liveness_silence_tracker.sv]
// ---------------------------------------------------------------------------
// window_liveness_silence_tracker
// Tracks windows by workspace/window key; reports silence, exits and drops.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake           | carries
//  req_ch   | in  | valid/ready         | mode, key, pid, time, wall stamp
//  rsp_ch   | out | valid/ready         | event kind, key, stamp, last
//  csr_*    | in  | APB setup + access  | silence_threshold_ms at 0x0
//
//  Observe transaction: accept, a scan of all TABLE_DEPTH entries, then a
//  resolve step that waits on a stalled result; the table walk is sequential.
//  End of round: accept, mode dispatch, then a sweep of all TABLE_DEPTH entries
//  that waits whenever the result side stalls.
//  One transaction at a time; req ready is high only while idle.
//  Reset (synchronous) empties the table at once and sets the threshold to 60000.
//  A stalled result holds in the output register; the walk waits on it.
// ---------------------------------------------------------------------------
module window_liveness_silence_tracker (
   input  logic                          clock,
   input  logic                          reset,
   wlst_req_if.sink                      req_ch,
   wlst_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [wlst_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import wlst_pkg::*;

   logic [31:0]    thresh_ff;
   ctl_cmd_type    cmd;
   ctl_status_type status;
   logic           thr_sel;

   // register index is paddr[2]; low two bits are byte lanes
   assign thr_sel    = (csr_paddr[2] == CSR_IDX_THRESH);
   assign csr_pready = 1'b1;
   assign csr_prdata = thr_sel ? thresh_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && thr_sel) begin
         thresh_ff <= csr_pwdata;
      end
   end

   // sequencer
   wlst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table and result register
   wlst_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .in_mode             (req_ch.mode),
      .in_workspace_id     (req_ch.workspace_id),
      .in_window_id        (req_ch.window_id),
      .in_proc_id          (req_ch.proc_id),
      .in_now_ms           (req_ch.now_ms),
      .in_wall_stamp       (req_ch.wall_stamp),
      .threshold           (thresh_ff),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_event_kind      (rsp_ch.event_kind),
      .rsp_event_workspace (rsp_ch.event_workspace),
      .rsp_event_window    (rsp_ch.event_window),
      .rsp_event_stamp     (rsp_ch.event_stamp),
      .rsp_last            (rsp_ch.last)
   );

endmodule

[design/wlst_checker.sv]
// ---------------------------------------------------------------------------
// wlst_checker
// Port-level checks of the window liveness tracker.
// ---------------------------------------------------------------------------
`include "window_liveness_silence_tracker_macros.svh"

module wlst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [23:0] rsp_key,
   input logic [31:0] rsp_stamp,
   input logic        rsp_last
);

   // a stalled result holds
   `WLST_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_kind, rsp_key, rsp_stamp, rsp_last}))

   // one transaction at a time
   `WLST_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)

   // reset leaves no result pending and the input open
   `WLST_ASSERT_ALWAYS(a_reset_clean, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind window_liveness_silence_tracker wlst_checker u_wlst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.event_kind),
   .rsp_key   ({rsp_ch.event_workspace, rsp_ch.event_window}),
   .rsp_stamp (rsp_ch.event_stamp),
   .rsp_last  (rsp_ch.last)
);

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// Window liveness tracker testbench
// Drives observe and end-of-round transactions, predicts the event stream
// with a behavioral copy of the tracking table and checks every event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import wlst_pkg::*;

   typedef struct packed {
      logic        mode;
      logic [7:0]  ws;
      logic [15:0] win;
      logic [21:0] pid;
      logic [47:0] now;
      logic [31:0] stamp;
   } snap_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  ws;
      logic [15:0] win;
      logic [31:0] stamp;
      logic        last;
   } evt_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_took = 1'b0;   // transaction taken at the last rising edge

   wlst_req_if req_ch ();
   wlst_rsp_if rsp_ch ();

   window_liveness_silence_tracker DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the tracking table
   logic [31:0] thresh_q;
   logic        trk_valid [TABLE_DEPTH];
   logic [23:0] trk_key   [TABLE_DEPTH];
   logic [21:0] trk_pid   [TABLE_DEPTH];
   logic [47:0] trk_start [TABLE_DEPTH];
   logic        trk_quiet [TABLE_DEPTH];
   logic        trk_seen  [TABLE_DEPTH];

   snap_type pending_snaps[$];
   evt_type  events_due[$];
   int    errors = 0;
   int    send_idle = 0;   // percent
   int    recv_idle = 0;
   int    hold_off = 0;    // long receiver stall, in cycles
   int    quiet_cycles = 0;

   // Works out the events one transaction causes and updates the table copy.
   task automatic track_snapshot(input snap_type s);
      logic [23:0] key;
      int hit, free_slot, first_evt;
      key = {s.ws, s.win};
      hit = -1;
      free_slot = -1;
      first_evt = events_due.size();
      if (s.mode == MODE_SWEEP) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (trk_valid[i] && !trk_seen[i]) begin
               events_due.insert(events_due.size(),
                                 '{KIND_EXITED, trk_key[i][23:16], trk_key[i][15:0],
                                   s.stamp, 1'b0});
               trk_valid[i] = 1'b0;
               trk_quiet[i] = 1'b0;
            end
            trk_seen[i] = 1'b0;
         end
      end else begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (trk_valid[i]) begin
               if (hit < 0 && trk_key[i] == key) hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit >= 0) begin
            trk_seen[hit] = 1'b1;
            if (trk_pid[hit] != s.pid) begin
               trk_pid[hit] = s.pid;
               trk_start[hit] = s.now;
               trk_quiet[hit] = 1'b0;
            end else if (!trk_quiet[hit] && (s.now - trk_start[hit]) >= {16'd0, thresh_q}) begin
               events_due.insert(events_due.size(),
                                 '{KIND_SILENCE, s.ws, s.win, s.stamp, 1'b0});
               trk_quiet[hit] = 1'b1;
            end
         end else if (free_slot >= 0) begin
            trk_valid[free_slot] = 1'b1;
            trk_key[free_slot] = key;
            trk_pid[free_slot] = s.pid;
            trk_start[free_slot] = s.now;
            trk_quiet[free_slot] = 1'b0;
            trk_seen[free_slot] = 1'b1;
         end else begin
            events_due.insert(events_due.size(), '{KIND_DROPPED, s.ws, s.win, s.stamp, 1'b0});
         end
      end
      if (events_due.size() > first_evt)
         events_due[events_due.size()-1].last = 1'b1;
   endtask

   // Driver: offers queued snapshots, idles at random at the falling edge.
   initial begin
      req_ch.valid = 1'b0;
      {req_ch.mode, req_ch.workspace_id, req_ch.window_id, req_ch.proc_id,
       req_ch.now_ms, req_ch.wall_stamp} = '0;
   end

   always @(posedge clock) begin
      req_took <= !reset && req_ch.valid && req_ch.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_took) begin
         // previous transaction (if any) was taken at the last rising edge
         if (pending_snaps.size() > 0 && $urandom_range(99) >= send_idle) begin
            snap_type s;
            s = pending_snaps.pop_front();
            req_ch.valid <= 1'b1;
            {req_ch.mode, req_ch.workspace_id, req_ch.window_id, req_ch.proc_id,
             req_ch.now_ms, req_ch.wall_stamp} <= s;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver ready, with the long hold-off counted here
   initial rsp_ch.ready = 1'b0;
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Monitor: predicts on accepted inputs, checks accepted events.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            track_snapshot({req_ch.mode, req_ch.workspace_id, req_ch.window_id,
                            req_ch.proc_id, req_ch.now_ms, req_ch.wall_stamp});
         if (rsp_ch.valid && rsp_ch.ready) begin
            evt_type got, want;
            got = {kind_type'(rsp_ch.event_kind), rsp_ch.event_workspace, rsp_ch.event_window,
                   rsp_ch.event_stamp, rsp_ch.last};
            if (events_due.size() == 0) begin
               $display("%0t: unexpected event, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = events_due.pop_front();
               if (got.kind !== want.kind || got.ws !== want.ws || got.win !== want.win ||
                   got.stamp !== want.stamp || got.last !== want.last) begin
                  $display("%0t: event mismatch, expected kind %0d ws %h win %h stamp %h last %b",
                           $time, want.kind, want.ws, want.win, want.stamp, want.last);
                  $display("%0t:                actual   kind %0d ws %h win %h stamp %h last %b",
                           $time, got.kind, got.ws, got.win, got.stamp, got.last);
                  errors++;
               end
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stimulus state: a small pool of windows so hits and repeats are common.
   logic [7:0]  pool_ws  [48];
   logic [15:0] pool_win [48];
   logic [21:0] pool_pid [48];
   logic [47:0] clock_ms;

   function automatic snap_type make_observe(int w, logic [47:0] t);
      snap_type s;
      s.mode = MODE_OBSERVE;
      s.ws = pool_ws[w];
      s.win = pool_win[w];
      s.pid = pool_pid[w];
      s.now = t;
      s.stamp = $urandom();
      return s;
   endfunction

   function automatic snap_type make_sweep();
      snap_type s;
      s = {$urandom(), $urandom(), $urandom()};
      s.mode = MODE_SWEEP;
      return s;
   endfunction

   task automatic csr_write(input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= '0; csr_pwdata <= value;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      thresh_q = value;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      while (pending_snaps.size() > 0 || req_ch.valid || events_due.size() > 0)
         @(posedge clock);
      repeat (3 * TABLE_DEPTH + 10) @(posedge clock);
   endtask

   // One phase of random rounds; mostly well-formed observe/sweep rounds.
   task automatic random_phase(input int n_items);
      int w;
      for (int k = 0; k < n_items; k++) begin
         clock_ms = clock_ms + $urandom_range(20000);
         if ($urandom_range(99) < 12) begin
            pending_snaps.insert(pending_snaps.size(), make_sweep());
         end else begin
            w = $urandom_range(47);
            if ($urandom_range(99) < 15) pool_pid[w] = $urandom();
            if ($urandom_range(99) < 3) clock_ms = {$urandom(), $urandom()};
            pending_snaps.insert(pending_snaps.size(), make_observe(w, clock_ms));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         trk_valid[i] = 1'b0; trk_quiet[i] = 1'b0; trk_seen[i] = 1'b0;
         trk_key[i] = '0; trk_pid[i] = '0; trk_start[i] = '0;
      end
      thresh_q = THRESH_RESET;
      for (int i = 0; i < 48; i++) begin
         pool_ws[i] = $urandom(); pool_win[i] = $urandom(); pool_pid[i] = $urandom();
      end
      pool_ws[0] = 8'h00; pool_win[0] = 16'h0000; pool_pid[0] = 22'h000000;
      pool_ws[1] = 8'hFF; pool_win[1] = 16'hFFFF; pool_pid[1] = 22'h3FFFFF;
      clock_ms = 48'd1000;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset threshold, first sight, silence, repeat, pid change,
      // wrap of the clock, full table, drop and sweep.
      pending_snaps.insert(pending_snaps.size(), make_observe(0, 48'd0));
      pending_snaps.insert(pending_snaps.size(), make_observe(0, 48'd59999));
      pending_snaps.insert(pending_snaps.size(), make_observe(0, 48'd60000));
      pending_snaps.insert(pending_snaps.size(), make_observe(0, 48'd70000));
      pending_snaps.insert(pending_snaps.size(), make_observe(1, 48'hFFFF_FFFF_FFF0));
      pending_snaps.insert(pending_snaps.size(), make_observe(1, 48'd60000));
      pool_pid[0] = 22'h155555;
      pending_snaps.insert(pending_snaps.size(), make_observe(0, 48'hFFFF_FFFF_FFFF));
      pending_snaps.insert(pending_snaps.size(), make_sweep());
      drain();
      csr_write(32'd0);
      pending_snaps.insert(pending_snaps.size(), make_observe(0, 48'd5));
      pending_snaps.insert(pending_snaps.size(), make_observe(0, 48'd5));
      for (int i = 2; i < 36; i++)
         pending_snaps.insert(pending_snaps.size(), make_observe(i, 48'd7));
      pending_snaps.insert(pending_snaps.size(), make_sweep());
      pending_snaps.insert(pending_snaps.size(), make_sweep());
      pending_snaps.insert(pending_snaps.size(), make_sweep());
      drain();

      // Random, sender 34% idle, receiver 72% idle
      csr_write(32'd15000);
      send_idle = 34; recv_idle = 72;
      random_phase(140);
      drain();
      // Receiver 34%, sender 72%; then a burst against a long hold-off
      csr_write(32'hFFFF_FFFF);
      send_idle = 72; recv_idle = 34;
      random_phase(60);
      pending_snaps.insert(pending_snaps.size(), make_sweep());
      wait (pending_snaps.size() == 0);
      send_idle = 0;
      hold_off = 600;
      for (int i = 2; i < 40; i++)
         pending_snaps.insert(pending_snaps.size(), make_observe(i, clock_ms));
      pending_snaps.insert(pending_snaps.size(), make_sweep());
      pending_snaps.insert(pending_snaps.size(), make_sweep());
      drain();
      // No idling
      csr_write(32'd40000);
      send_idle = 0; recv_idle = 0;
      random_phase(140);
      pending_snaps.insert(pending_snaps.size(), make_sweep());
      pending_snaps.insert(pending_snaps.size(), make_sweep());
      drain();

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[window_liveness_silence_tracker.f]
+incdir+design
design/wlst_pkg.sv
design/wlst_if.sv
design/wlst_ctrl.sv
design/wlst_dpath.sv
design/window_liveness_silence_tracker.sv
design/wlst_checker.sv
dv/testbench.sv
